FILE: src/crash_latch_with_alarm_timers_macros.svh
// Assertion macros used by the checker file.
`ifndef CRASH_LATCH_WITH_ALARM_TIMERS_MACROS_SVH
`define CRASH_LATCH_WITH_ALARM_TIMERS_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CLA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define CLA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: src/cla_pkg.sv
// ----------------------------------------------------------------------------
// cla_pkg
// Types, widths, register indexes and reset values of the crash latch block.
// ----------------------------------------------------------------------------
package cla_pkg;

  localparam int unsigned AXIS_W  = 16;
  localparam int unsigned SQ_W    = 32;
  localparam int unsigned SUM_W   = 34;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned MS_W    = 16;
  localparam int unsigned IDX_W   = 8;
  localparam int unsigned DATA_W  = 32;

  // Register indexes on the configuration port.
  localparam logic [IDX_W-1:0] REG_THRESHOLD_SQ  = 8'd0;
  localparam logic [IDX_W-1:0] REG_BUZZER_MS     = 8'd1;
  localparam logic [IDX_W-1:0] REG_EMERGENCY_MS  = 8'd2;
  localparam logic [IDX_W-1:0] REG_SAFE_MS       = 8'd3;

  // Reset values; 40960^2 is 5 g at 8192 LSB per g.
  localparam logic [SQ_W-1:0] THRESHOLD_RST    = 32'd1677721600;
  localparam logic [MS_W-1:0] BUZZER_MS_RST    = 16'd5000;
  localparam logic [MS_W-1:0] EMERGENCY_MS_RST = 16'd100;
  localparam logic [MS_W-1:0] SAFE_MS_RST      = 16'd500;

  localparam logic REQ_TICK   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  typedef struct packed {
    logic [SQ_W-1:0] threshold_sq;
    logic [MS_W-1:0] buzzer_ms;
    logic [MS_W-1:0] emergency_period_ms;
    logic [MS_W-1:0] safe_period_ms;
  } cfg_t;

  // Item after the squaring stage.
  typedef struct packed {
    logic            req_type;
    logic            tx_free;
    logic [SQ_W-1:0] sq_x;
    logic [SQ_W-1:0] sq_y;
    logic [SQ_W-1:0] sq_z;
  } sq_item_t;

  // Magnitude of a signed axis; the most negative value maps to 32768.
  function automatic logic [AXIS_W-1:0] abs_axis(input logic signed [AXIS_W-1:0] v);
    logic [AXIS_W-1:0] u;
    begin
      u = v;
      abs_axis = u[AXIS_W-1] ? (~u + 16'd1) : u;
    end
  endfunction

endpackage

FILE: src/cla_cfg_regs.sv
// ----------------------------------------------------------------------------
// cla_cfg_regs
// Configuration register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module cla_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic [cla_pkg::IDX_W-1:0]   wr_index,
  input  logic [cla_pkg::DATA_W-1:0]  wr_data,
  output cla_pkg::cfg_t               cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold_sq        <= cla_pkg::THRESHOLD_RST;
      cfg.buzzer_ms           <= cla_pkg::BUZZER_MS_RST;
      cfg.emergency_period_ms <= cla_pkg::EMERGENCY_MS_RST;
      cfg.safe_period_ms      <= cla_pkg::SAFE_MS_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        cla_pkg::REG_THRESHOLD_SQ: cfg.threshold_sq        <= wr_data;
        cla_pkg::REG_BUZZER_MS:    cfg.buzzer_ms           <= wr_data[cla_pkg::MS_W-1:0];
        cla_pkg::REG_EMERGENCY_MS: cfg.emergency_period_ms <= wr_data[cla_pkg::MS_W-1:0];
        cla_pkg::REG_SAFE_MS:      cfg.safe_period_ms      <= wr_data[cla_pkg::MS_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: src/cla_square_stage.sv
// ----------------------------------------------------------------------------
// cla_square_stage
// Input register: squares each axis magnitude on the way in.
// ----------------------------------------------------------------------------
module cla_square_stage (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               req_type,
  input  logic signed [cla_pkg::AXIS_W-1:0]  accel_x,
  input  logic signed [cla_pkg::AXIS_W-1:0]  accel_y,
  input  logic signed [cla_pkg::AXIS_W-1:0]  accel_z,
  input  logic                               tx_free,
  input  logic                               take,
  output logic                               item_valid,
  output cla_pkg::sq_item_t                  item
);

  logic [cla_pkg::AXIS_W-1:0] mag_x;
  logic [cla_pkg::AXIS_W-1:0] mag_y;
  logic [cla_pkg::AXIS_W-1:0] mag_z;
  logic                       accept;

  assign mag_x    = cla_pkg::abs_axis(accel_x);
  assign mag_y    = cla_pkg::abs_axis(accel_y);
  assign mag_z    = cla_pkg::abs_axis(accel_z);
  // Hold off only while the held item cannot move on.
  assign in_stall = item_valid && !take;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (take) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.req_type <= req_type;
      item.tx_free  <= tx_free;
      item.sq_x     <= {16'd0, mag_x} * {16'd0, mag_x};
      item.sq_y     <= {16'd0, mag_y} * {16'd0, mag_y};
      item.sq_z     <= {16'd0, mag_z} * {16'd0, mag_z};
    end
  end

endmodule

FILE: src/cla_eval_stage.sv
// ----------------------------------------------------------------------------
// cla_eval_stage
// Crash test, timers and message requests; owns the state and result register.
// ----------------------------------------------------------------------------
module cla_eval_stage (
  input  logic               clk,
  input  logic               rst,
  input  cla_pkg::cfg_t      cfg,
  input  logic               item_valid,
  input  cla_pkg::sq_item_t  item,
  output logic               take,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               crashed,
  output logic               buzzer_on,
  output logic               send_message,
  output logic               message_value
);

  logic [cla_pkg::TIME_W-1:0] now_ms;
  logic                       crash_flag;
  logic [cla_pkg::TIME_W-1:0] crash_stamp;
  logic [cla_pkg::TIME_W-1:0] last_emergency_stamp;
  logic [cla_pkg::TIME_W-1:0] last_safe_stamp;
  logic                       buzzer_state;

  logic [cla_pkg::TIME_W-1:0] now_ms_next;
  logic                       crash_flag_next;
  logic [cla_pkg::TIME_W-1:0] crash_stamp_next;
  logic [cla_pkg::TIME_W-1:0] last_emergency_stamp_next;
  logic [cla_pkg::TIME_W-1:0] last_safe_stamp_next;
  logic                       buzzer_state_next;
  logic                       send_next;

  logic [cla_pkg::SUM_W-1:0]  mag_sum;
  logic                       over;
  logic [cla_pkg::TIME_W-1:0] since_crash;
  logic [cla_pkg::TIME_W-1:0] since_emergency;
  logic [cla_pkg::TIME_W-1:0] since_safe;
  logic                       load_ok;

  assign load_ok = !out_valid || !out_stall;
  assign take    = item_valid && load_ok;

  assign mag_sum = {2'b00, item.sq_x} + {2'b00, item.sq_y} + {2'b00, item.sq_z};
  assign over    = mag_sum > {2'b00, cfg.threshold_sq};

  always_comb begin
    now_ms_next               = now_ms;
    crash_flag_next           = crash_flag;
    crash_stamp_next          = crash_stamp;
    last_emergency_stamp_next = last_emergency_stamp;
    last_safe_stamp_next      = last_safe_stamp;
    buzzer_state_next         = buzzer_state;
    send_next                 = 1'b0;
    since_crash               = '0;
    since_emergency           = now_ms - last_emergency_stamp;
    since_safe                = now_ms - last_safe_stamp;
    if (item.req_type == cla_pkg::REQ_TICK) begin
      now_ms_next = now_ms + 32'd1;
    end else begin
      if (!crash_flag && over) begin
        crash_flag_next  = 1'b1;
        crash_stamp_next = now_ms;
      end
      if (crash_flag_next) begin
        since_crash       = now_ms - crash_stamp_next;
        buzzer_state_next = since_crash <= {16'd0, cfg.buzzer_ms};
        if (since_emergency >= {16'd0, cfg.emergency_period_ms}) begin
          last_emergency_stamp_next = now_ms;
          send_next                 = item.tx_free;
        end
      end else if (since_safe >= {16'd0, cfg.safe_period_ms}) begin
        last_safe_stamp_next = now_ms;
        send_next            = item.tx_free;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now_ms               <= '0;
      crash_flag           <= 1'b0;
      crash_stamp          <= '0;
      last_emergency_stamp <= '0;
      last_safe_stamp      <= '0;
      buzzer_state         <= 1'b0;
      out_valid            <= 1'b0;
    end else begin
      if (take) begin
        now_ms               <= now_ms_next;
        crash_flag           <= crash_flag_next;
        crash_stamp          <= crash_stamp_next;
        last_emergency_stamp <= last_emergency_stamp_next;
        last_safe_stamp      <= last_safe_stamp_next;
        buzzer_state         <= buzzer_state_next;
        out_valid            <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      crashed       <= crash_flag_next;
      buzzer_on     <= buzzer_state_next;
      send_message  <= send_next;
      message_value <= crash_flag_next;
    end
  end

endmodule

FILE: src/crash_latch_with_alarm_timers.sv
// ----------------------------------------------------------------------------
// crash_latch_with_alarm_timers
// Latches a crash on an over-threshold squared acceleration and paces alarms.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+---------------------------------------------
//  in      | in_valid / in_stall    | req_type, accel_x/y/z, tx_free
//  out     | out_valid / out_stall  | crashed, buzzer_on, send_message, message_value
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Each transaction passes the input register, which squares the three axes,
// then the result register, which takes the crash test and timers. One
// transaction is accepted per cycle while no result is stalled at the output;
// the limit is the state update in the evaluation stage. Reset clears the
// clock, latch, stamps and buzzer and restores the register defaults. in_stall
// rises only while the input register is full and a result is stalled there.
// ----------------------------------------------------------------------------
module crash_latch_with_alarm_timers (
  input  logic                               clk,
  input  logic                               rst,
  // Input transactions
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               req_type,
  input  logic signed [cla_pkg::AXIS_W-1:0]  accel_x,
  input  logic signed [cla_pkg::AXIS_W-1:0]  accel_y,
  input  logic signed [cla_pkg::AXIS_W-1:0]  accel_z,
  input  logic                               tx_free,
  // Result transactions
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               crashed,
  output logic                               buzzer_on,
  output logic                               send_message,
  output logic                               message_value,
  // Configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [cla_pkg::IDX_W-1:0]          cfg_index,
  input  logic [cla_pkg::DATA_W-1:0]         cfg_data
);

  cla_pkg::cfg_t     cfg;
  cla_pkg::sq_item_t item;
  logic              item_valid;
  logic              take;

  // Registers must be written only while idle; unchecked, so always take the write.
  assign cfg_ready = 1'b1;

  cla_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Square each axis as the transaction is captured.
  cla_square_stage u_sq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .accel_x    (accel_x),
    .accel_y    (accel_y),
    .accel_z    (accel_z),
    .tx_free    (tx_free),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  // Advance the clock, latch a crash and pace the messages.
  cla_eval_stage u_eval (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .item_valid    (item_valid),
    .item          (item),
    .take          (take),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .crashed       (crashed),
    .buzzer_on     (buzzer_on),
    .send_message  (send_message),
    .message_value (message_value)
  );

endmodule

FILE: src/cla_checker.sv
// ----------------------------------------------------------------------------
// cla_checker
// Port-level checks of the crash latch block, bound to the top level.
// ----------------------------------------------------------------------------
`include "crash_latch_with_alarm_timers_macros.svh"

module cla_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic                               crashed,
  input logic                               buzzer_on,
  input logic                               send_message,
  input logic                               message_value
);

  // A crash result is followed directly by a crash result or by no result.
  `CLA_ASSERT_NEXT(a_crash_latched, clk, rst, out_valid && crashed, !out_valid || crashed)
  // The message payload mirrors the latch.
  `CLA_ASSERT_NOW(a_msg_is_latch, clk, rst, out_valid, message_value == crashed)
  // The buzzer only sounds after a crash.
  `CLA_ASSERT_NOW(a_buzzer_needs_crash, clk, rst, out_valid && buzzer_on, crashed)
  // Input is held back only behind a stalled result.
  `CLA_ASSERT_NOW(a_stall_cause, clk, rst, in_stall, out_valid && out_stall)
  // A stalled result stays valid, with crashed and send_message held.
  `CLA_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(crashed) && $stable(send_message))

endmodule

bind crash_latch_with_alarm_timers cla_checker u_cla_checker (.*);

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the crash latch with alarm timers.
// A short scripted sequence covers reset values, full-scale axes, the
// squared-magnitude boundary, zero and maximum periods, ignored register
// indexes and the first crash. Random phases follow, first on the safe side
// and then with the crash latched. Each accepted transaction is run through
// a local predictor, and every result is checked in order, field by field.
// ----------------------------------------------------------------------------
module tb;
  import cla_pkg::*;

  // Largest squared magnitude three axes can reach: 3 * 32768^2.
  localparam logic [SQ_W-1:0]  THRESHOLD_MAX = 32'd3221225472;
  // Register indexes past the last register; writes there must be dropped.
  localparam logic [IDX_W-1:0] REG_UNUSED_LO = 8'd4;
  localparam logic [IDX_W-1:0] REG_UNUSED_HI = 8'd255;
  localparam logic [MS_W-1:0]  MS_MAX        = 16'hFFFF;
  // Axis limit that selects the full signed range in the random items.
  localparam int unsigned      FULL_SCALE    = 32768;
  // Axis limit that keeps 3 * lim^2 well below the thresholds of the safe side.
  localparam int unsigned      QUIET_SCALE   = 18000;

  typedef struct packed {
    logic                     req_type;
    logic signed [AXIS_W-1:0] accel_x;
    logic signed [AXIS_W-1:0] accel_y;
    logic signed [AXIS_W-1:0] accel_z;
    logic                     tx_free;
  } sensor_item_t;

  typedef struct packed {
    logic crashed;
    logic buzzer_on;
    logic send_message;
    logic message_value;
  } alarm_status_t;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  // One line of the scripted part: a register write or an input transaction,
  // optionally with its result typed in by hand.
  typedef struct packed {
    row_kind_t        kind;
    sensor_item_t     item;
    logic [IDX_W-1:0] index;
    logic [DATA_W-1:0] data;
    logic             known;
    alarm_status_t    status;
  } script_row_t;

  // --------------------------------------------------------------------------
  // Clock, reset and block pins
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                     in_valid  = 1'b0;
  logic                     req_type  = 1'b0;
  logic signed [AXIS_W-1:0] accel_x   = '0;
  logic signed [AXIS_W-1:0] accel_y   = '0;
  logic signed [AXIS_W-1:0] accel_z   = '0;
  logic                     tx_free   = 1'b0;
  logic                     out_stall = 1'b0;
  logic                     cfg_valid = 1'b0;
  logic [IDX_W-1:0]         cfg_index = '0;
  logic [DATA_W-1:0]        cfg_data  = '0;

  logic in_stall;
  logic out_valid;
  logic crashed;
  logic buzzer_on;
  logic send_message;
  logic message_value;
  logic cfg_ready;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  crash_latch_with_alarm_timers dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .req_type      (req_type),
    .accel_x       (accel_x),
    .accel_y       (accel_y),
    .accel_z       (accel_z),
    .tx_free       (tx_free),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .crashed       (crashed),
    .buzzer_on     (buzzer_on),
    .send_message  (send_message),
    .message_value (message_value),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Predictor state: register settings plus the block's clock, latch and stamps
  // --------------------------------------------------------------------------
  logic [SQ_W-1:0]   thr_sq       = THRESHOLD_RST;
  logic [MS_W-1:0]   buzz_ms      = BUZZER_MS_RST;
  logic [MS_W-1:0]   emer_ms      = EMERGENCY_MS_RST;
  logic [MS_W-1:0]   safe_ms      = SAFE_MS_RST;
  logic [TIME_W-1:0] clock_ms     = '0;
  logic [TIME_W-1:0] crash_at     = '0;
  logic [TIME_W-1:0] last_emer_at = '0;
  logic [TIME_W-1:0] last_safe_at = '0;
  logic              latched      = 1'b0;
  logic              buzzing      = 1'b0;

  // Results still owed by the block, oldest first.
  alarm_status_t pending_status[$];
  alarm_status_t want;
  int unsigned   mismatches = 0;

  // Idling controls: a calm flag suppresses gaps for a stretch on that side.
  bit          sender_calm = 1'b0;
  bit          rx_calm     = 1'b0;
  int unsigned stall_left  = 0;

  script_row_t pre_crash_script[$];
  script_row_t crash_script[$];

  // Exact square of one raw axis; the most negative code squares to 2^30.
  function automatic logic [SUM_W-1:0] axis_sq(logic signed [AXIS_W-1:0] a);
    logic signed [AXIS_W:0] w;
    logic [AXIS_W:0]        m;
    w = a;
    m = (w < 0) ? -w : w;
    return SUM_W'(m) * SUM_W'(m);
  endfunction

  // Advance the predictor by one transaction and return the result it owes.
  function automatic alarm_status_t predict_status(sensor_item_t it);
    logic [SUM_W-1:0]  mag;
    logic [TIME_W-1:0] since_crash;
    logic [TIME_W-1:0] since_emer;
    logic [TIME_W-1:0] since_safe;
    alarm_status_t     st;
    st.send_message = 1'b0;
    if (it.req_type == REQ_TICK) begin
      clock_ms = clock_ms + 1'b1;
    end else begin
      mag = axis_sq(it.accel_x) + axis_sq(it.accel_y) + axis_sq(it.accel_z);
      // Strictly above the threshold latches; equal does not.
      if (!latched && mag > {2'b00, thr_sq}) begin
        latched  = 1'b1;
        crash_at = clock_ms;
      end
      if (latched) begin
        since_crash = clock_ms - crash_at;
        buzzing     = since_crash <= {16'h0, buzz_ms};
        since_emer  = clock_ms - last_emer_at;
        // The stamp moves even when no mailbox is free.
        if (since_emer >= {16'h0, emer_ms}) begin
          last_emer_at    = clock_ms;
          st.send_message = it.tx_free;
        end
      end else begin
        since_safe = clock_ms - last_safe_at;
        if (since_safe >= {16'h0, safe_ms}) begin
          last_safe_at    = clock_ms;
          st.send_message = it.tx_free;
        end
      end
    end
    st.crashed       = latched;
    st.buzzer_on     = buzzing;
    st.message_value = latched;
    return st;
  endfunction

  // Mirror a register write; indexes past the last register change nothing.
  function automatic void apply_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] value);
    case (idx)
      REG_THRESHOLD_SQ: thr_sq  = value[SQ_W-1:0];
      REG_BUZZER_MS:    buzz_ms = value[MS_W-1:0];
      REG_EMERGENCY_MS: emer_ms = value[MS_W-1:0];
      REG_SAFE_MS:      safe_ms = value[MS_W-1:0];
      default: ;
    endcase
  endfunction

  // Gap or stall length: mostly short, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic signed [AXIS_W-1:0] random_axis(int unsigned lim);
    logic signed [AXIS_W-1:0] v;
    int unsigned              pick;
    if (lim >= FULL_SCALE) begin
      // Full range, with the codes at both ends and zero showing up often.
      pick = $urandom_range(0, 15);
      if (pick == 0)      v = 16'sh8000;
      else if (pick == 1) v = 16'sh7FFF;
      else if (pick == 2) v = '0;
      else                v = AXIS_W'($urandom);
    end else begin
      v = AXIS_W'($urandom_range(0, lim));
      if ($urandom_range(0, 1) == 1) v = -v;
    end
    return v;
  endfunction

  function automatic sensor_item_t random_item(int unsigned lim);
    sensor_item_t it;
    it.req_type = ($urandom_range(0, 99) < 40) ? REQ_TICK : REQ_SAMPLE;
    it.accel_x  = random_axis(lim);
    it.accel_y  = random_axis(lim);
    it.accel_z  = random_axis(lim);
    it.tx_free  = ($urandom_range(0, 3) != 0);
    return it;
  endfunction

  function automatic script_row_t item_row(logic req, logic signed [AXIS_W-1:0] x, y, z,
                                           logic txf);
    script_row_t r;
    r              = '0;
    r.kind         = ROW_ITEM;
    r.item.req_type = req;
    r.item.accel_x = x;
    r.item.accel_y = y;
    r.item.accel_z = z;
    r.item.tx_free = txf;
    return r;
  endfunction

  function automatic script_row_t checked_row(logic req, logic signed [AXIS_W-1:0] x, y, z,
                                              logic txf, alarm_status_t st);
    script_row_t r;
    r        = item_row(req, x, y, z, txf);
    r.known  = 1'b1;
    r.status = st;
    return r;
  endfunction

  function automatic script_row_t reg_row(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] value);
    script_row_t r;
    r       = '0;
    r.kind  = ROW_REG;
    r.index = idx;
    r.data  = value;
    return r;
  endfunction

  task automatic check_field(string name, logic want_bit, logic got_bit);
    if (got_bit !== want_bit) begin
      $display("%0t: %s expected %0b, got %0b", $time, name, want_bit, got_bit);
      mismatches++;
    end
  endtask

  // Drop both request lines and hold until every owed result is out.
  task automatic wait_drained();
    in_valid  <= 1'b0;
    cfg_valid <= 1'b0;
    do @(posedge clk); while (pending_status.size() != 0);
  endtask

  // Register write, only ever issued with the block empty.
  task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, value);
  endtask

  // Present one input transaction, hold it through any stall, then log the
  // result it owes. A hand-typed result replaces the predicted one.
  task automatic push_item(sensor_item_t it, logic known, alarm_status_t given);
    alarm_status_t predicted;
    int unsigned   gap;
    cfg_valid <= 1'b0;
    in_valid  <= 1'b1;
    req_type  <= it.req_type;
    accel_x   <= it.accel_x;
    accel_y   <= it.accel_y;
    accel_z   <= it.accel_z;
    tx_free   <= it.tx_free;
    do @(posedge clk); while (in_stall);
    predicted = predict_status(it);
    pending_status.push_back(known ? given : predicted);
    gap = (!sender_calm && $urandom_range(0, 1) == 0) ? idle_len() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic run_script(input script_row_t rows[$]);
    foreach (rows[i]) begin
      if (rows[i].kind == ROW_REG) begin
        write_reg(rows[i].index, rows[i].data);
      end else begin
        push_item(rows[i].item, rows[i].known, rows[i].status);
      end
    end
  endtask

  task automatic random_phase(int unsigned count, int unsigned lim);
    repeat (count) begin
      if ($urandom_range(0, 63) == 0) sender_calm = ~sender_calm;
      // Now and then hold the sender until the block has emptied.
      if ($urandom_range(0, 299) == 0) wait_drained();
      push_item(random_item(lim), 1'b0, '0);
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: check each accepted result, then pick the next stall value
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_status.size() == 0) begin
        $display("%0t: result with no transaction outstanding", $time);
        mismatches++;
      end else begin
        want = pending_status.pop_front();
        check_field("crashed", want.crashed, crashed);
        check_field("buzzer_on", want.buzzer_on, buzzer_on);
        check_field("send_message", want.send_message, send_message);
        check_field("message_value", want.message_value, message_value);
      end
    end
    if ($urandom_range(0, 255) == 0) rx_calm = ~rx_calm;
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
      out_stall <= 1'b1;
    end else if (!rx_calm && $urandom_range(0, 3) == 0) begin
      stall_left = idle_len() - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    // Safe side, before any crash. Typed results follow from the register
    // values and the millisecond count, which stays tiny here.
    pre_crash_script = '{
      // Reset values: period 500 has not elapsed at time zero.
      checked_row(REQ_SAMPLE, 0, 0, 0, 1'b1, 4'b0000),
      // A tick ignores the axes and the mailbox flag.
      checked_row(REQ_TICK, -1, 32767, -32768, 1'b1, 4'b0000),
      reg_row(REG_THRESHOLD_SQ, THRESHOLD_MAX),
      reg_row(REG_SAFE_MS, 32'd0),
      // Magnitude equal to the threshold does not latch; period zero sends.
      checked_row(REQ_SAMPLE, -32768, -32768, -32768, 1'b1, 4'b0010),
      // Period elapsed but no mailbox free: no message.
      checked_row(REQ_SAMPLE, 32767, 32767, 32767, 1'b0, 4'b0000),
      reg_row(REG_SAFE_MS, {16'h0, MS_MAX}),
      checked_row(REQ_SAMPLE, 0, 0, 0, 1'b1, 4'b0000),
      reg_row(REG_SAFE_MS, 32'd1),
      checked_row(REQ_TICK, 0, 0, 0, 1'b0, 4'b0000),
      checked_row(REQ_SAMPLE, -32768, 0, 0, 1'b1, 4'b0010),
      checked_row(REQ_SAMPLE, 0, -32768, 0, 1'b1, 4'b0000),
      // Writes past the last register: neither threshold nor period may move.
      reg_row(REG_UNUSED_LO, 32'd0),
      reg_row(REG_UNUSED_HI, 32'd0),
      checked_row(REQ_SAMPLE, 0, 0, -32768, 1'b1, 4'b0000),
      item_row(REQ_TICK, 12345, -2, 7, 1'b0)
    };

    // First crash, at the lowest threshold and the smallest nonzero axis.
    crash_script = '{
      reg_row(REG_BUZZER_MS, 32'd0),
      reg_row(REG_EMERGENCY_MS, 32'd0),
      reg_row(REG_THRESHOLD_SQ, 32'd0),
      // Zero magnitude is not above a zero threshold.
      item_row(REQ_SAMPLE, 0, 0, 0, 1'b1),
      checked_row(REQ_SAMPLE, 1, 0, 0, 1'b1, 4'b1111),
      // A tick keeps the buzzer as the last sample left it.
      checked_row(REQ_TICK, -32768, -32768, -32768, 1'b1, 4'b1101),
      // One millisecond past a zero buzzer time: buzzer off.
      checked_row(REQ_SAMPLE, 0, 0, 0, 1'b0, 4'b1001),
      reg_row(REG_BUZZER_MS, {16'h0, MS_MAX}),
      reg_row(REG_EMERGENCY_MS, {16'h0, MS_MAX}),
      checked_row(REQ_SAMPLE, 0, 0, 0, 1'b1, 4'b1101),
      // The latch holds: a full-scale sample does not restamp the crash.
      item_row(REQ_SAMPLE, 32767, 32767, 32767, 1'b1),
      reg_row(REG_EMERGENCY_MS, 32'd1),
      checked_row(REQ_TICK, 5, 5, 5, 1'b0, 4'b1101),
      checked_row(REQ_SAMPLE, -1, -1, -1, 1'b1, 4'b1111)
    };

    // Hold reset at the start, then release it for good.
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    run_script(pre_crash_script);

    // Safe side: with the threshold at its ceiling no sample can latch.
    write_reg(REG_SAFE_MS, 32'd0);
    random_phase(250, FULL_SCALE);
    write_reg(REG_SAFE_MS, 32'd1);
    random_phase(250, FULL_SCALE);
    write_reg(REG_SAFE_MS, $urandom_range(2, 12));
    random_phase(250, FULL_SCALE);
    // Lower threshold, axes kept small enough to stay below it.
    write_reg(REG_THRESHOLD_SQ, $urandom_range(1700000000, THRESHOLD_MAX));
    write_reg(REG_SAFE_MS, $urandom_range(0, 8));
    random_phase(200, QUIET_SCALE);
    write_reg(REG_SAFE_MS, {16'h0, MS_MAX});
    random_phase(100, QUIET_SCALE);

    run_script(crash_script);

    // Crash latched: sweep buzzer time and emergency spacing.
    write_reg(REG_BUZZER_MS, $urandom_range(1, 30));
    write_reg(REG_EMERGENCY_MS, 32'd1);
    random_phase(250, FULL_SCALE);
    write_reg(REG_BUZZER_MS, 32'd0);
    write_reg(REG_EMERGENCY_MS, 32'd0);
    random_phase(150, FULL_SCALE);
    write_reg(REG_BUZZER_MS, {16'h0, MS_MAX});
    write_reg(REG_EMERGENCY_MS, $urandom_range(2, 10));
    random_phase(250, FULL_SCALE);
    write_reg(REG_THRESHOLD_SQ, $urandom);
    write_reg(REG_BUZZER_MS, $urandom_range(5, 80));
    write_reg(REG_EMERGENCY_MS, $urandom_range(0, 5));
    random_phase(250, FULL_SCALE);

    // Drain, let the pipeline settle, then report.
    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_status.size() == 0) begin
      $display("** crash_latch_with_alarm_timers: PASSED **");
    end else begin
      $display("** crash_latch_with_alarm_timers: FAILED **");
    end
    $finish;
  end

  // Stop a hung run long after the slowest passing one would have ended.
  initial begin
    #2000000;
    $display("** crash_latch_with_alarm_timers: FAILED **");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+src
src/cla_pkg.sv
src/cla_cfg_regs.sv
src/cla_square_stage.sv
src/cla_eval_stage.sv
src/crash_latch_with_alarm_timers.sv
src/cla_checker.sv
sim/tb.sv
